@@ rtl/sha256_pkg.sv @@
// Shared types, constants and tables for the SHA-256 message hasher.
// No dependencies; imported by every module of the block but the output checker.
package sha256_pkg;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Padding and block geometry
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One queued input item
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } item_t;

    // Commands from the sequencer to the compression core
    typedef struct packed {
        logic        init;
        logic        start;
        logic        byte_we;
        logic [5:0]  byte_pos;
        logic [7:0]  byte_val;
        logic        len_we;
        logic [63:0] len;
    } core_cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD_BLK,
        ST_PAD_LEN,
        ST_EMIT
    } back_state_t;

    // Initial hash values
    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Round constants
    function automatic logic [31:0] k_const(input logic [5:0] idx);
        logic [31:0] v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/sha256_front.sv @@
// Front end of the SHA-256 hasher: accepts input beats into a short queue.
// Depends on sha256_pkg for the queued item type.
module sha256_front #(
    parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_kind,
    input  logic [7:0]          in_data,
    output logic                out_valid,
    output sha256_pkg::item_t   out_item,
    input  logic                pop
);
    import sha256_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               take;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign take      = pop && out_valid;
    assign out_item  = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat, classified by kind
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{kind: in_kind, data: in_data};
        end
    end

endmodule

@@ rtl/sha256_core.sv @@
// SHA-256 compression core: block buffer as schedule window, one round per cycle,
// chaining words. Depends on sha256_pkg for constants and the command struct.
module sha256_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256_pkg::core_cmd_t   cmd,
    output logic                    busy,
    output logic [7:0][31:0]        chain
);
    import sha256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction

    logic [15:0][31:0] w_reg;
    logic [7:0][31:0]  v_reg;
    logic [7:0][31:0]  h_reg;
    logic [5:0]        round_reg;
    logic              run_reg;
    logic              fin_reg;

    logic [31:0] e, a, big1, big0, choose, major, t1, sched_new;
    logic [31:0] sig0, sig1;
    logic [4:0]  lane_sh;

    // Round and schedule datapath
    always_comb
    begin
        e      = v_reg[4];
        a      = v_reg[0];
        big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        choose = (e & v_reg[5]) ^ (~e & v_reg[6]);
        t1     = v_reg[7] + big1 + choose + k_const(round_reg) + w_reg[0];
        big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        major  = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        sig0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        sched_new = w_reg[0] + sig0 + w_reg[9] + sig1;
    end

    // Big-endian byte lane inside the word
    assign lane_sh = {~cmd.byte_pos[1:0], 3'b000};
    assign busy    = run_reg || fin_reg;
    assign chain   = h_reg;

    // Block buffer: byte and length writes, then shift as the schedule window
    always_ff @(posedge clk)
    begin
        priority if (run_reg)
        begin
            w_reg <= {sched_new, w_reg[15:1]};
        end
        else if (cmd.len_we)
        begin
            w_reg[14] <= cmd.len[63:32];
            w_reg[15] <= cmd.len[31:0];
        end
        else if (cmd.byte_we)
        begin
            w_reg[cmd.byte_pos[5:2]][lane_sh +: 8] <= cmd.byte_val;
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            v_reg <= h_reg;
        end
        else if (run_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= e;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= a;
            v_reg[0] <= t1 + big0 + major;
        end
    end

    // Round sequencing and chaining update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= iv_const(3'(i));
            end
        end
        else
        begin
            fin_reg <= 1'b0;
            if (cmd.start)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                round_reg <= round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            if (cmd.init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= iv_const(3'(i));
                end
            end
            else if (fin_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

endmodule

@@ rtl/sha256_back.sv @@
// Back end of the SHA-256 hasher: block filling, padding, compression control
// and the digest output register. Depends on sha256_pkg.
module sha256_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  sha256_pkg::item_t       item,
    output logic                    pop,
    output sha256_pkg::core_cmd_t   cmd,
    input  logic                    core_busy,
    input  logic [7:0][31:0]        chain,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             out_word,
    output logic [2:0]              out_index,
    output logic                    out_last
);
    import sha256_pkg::*;

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [2:0]  emit_reg, emit_next;
    logic        load_out;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_index_reg;
    logic        out_last_reg;

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Next state and counters
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        fill_next   = fill_reg;
        bitcnt_next = bitcnt_reg;
        emit_next   = emit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    fill_next = fill_reg + 1'b1;
                    if (item.kind == KIND_BYTE)
                    begin
                        bitcnt_next = bitcnt_reg + BITS_PER_BYTE;
                        if (fill_reg == LAST_POS)
                        begin
                            state_next = ST_COMP;
                            ret_next   = ST_IDLE;
                        end
                    end
                    else
                    begin
                        priority if (fill_reg == LAST_POS)
                        begin
                            state_next = ST_COMP;
                            ret_next   = ST_PAD_LEN;
                        end
                        else if (fill_reg >= LEN_POS)
                        begin
                            state_next = ST_PAD_BLK;
                        end
                        else
                        begin
                            state_next = ST_PAD_LEN;
                        end
                    end
                end
            end
            ST_PAD_BLK:
            begin
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_PAD_LEN;
                end
            end
            ST_PAD_LEN:
            begin
                if (fill_reg == LEN_POS)
                begin
                    fill_next  = '0;
                    emit_next  = '0;
                    state_next = ST_COMP;
                    ret_next   = ST_EMIT;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_COMP:
            begin
                if (!core_busy)
                begin
                    state_next = ret_reg;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_reg == LAST_WORD_IDX)
                    begin
                        bitcnt_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the queue and the core
    always_comb
    begin
        pop = 1'b0;
        cmd = '0;
        cmd.byte_pos = fill_reg;
        cmd.len      = bitcnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop          = 1'b1;
                    cmd.byte_we  = 1'b1;
                    cmd.byte_val = (item.kind == KIND_END) ? PAD_BYTE : item.data;
                    cmd.start    = (fill_reg == LAST_POS);
                end
            end
            ST_PAD_BLK:
            begin
                cmd.byte_we = 1'b1;
                cmd.start   = (fill_reg == LAST_POS);
            end
            ST_PAD_LEN:
            begin
                if (fill_reg == LEN_POS)
                begin
                    cmd.len_we = 1'b1;
                    cmd.start  = 1'b1;
                end
                else
                begin
                    cmd.byte_we = 1'b1;
                end
            end
            ST_COMP:
            begin
                cmd.init = 1'b0;
            end
            ST_EMIT:
            begin
                cmd.init = load_out && (emit_reg == LAST_WORD_IDX);
            end
            default:
            begin
                cmd.init = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            bitcnt_reg    <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            fill_reg   <= fill_next;
            bitcnt_reg <= bitcnt_next;
            emit_reg   <= emit_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Digest output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_word_reg  <= chain[emit_reg];
            out_index_reg <= emit_reg;
            out_last_reg  <= (emit_reg == LAST_WORD_IDX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/sha256_message_hasher_top.sv @@
// SHA-256 message hasher: byte stream in, eight digest words out.
// Usage:
//   Input beats on s_axis_*: tuser is the kind (0 = message byte in tdata,
//   1 = end of message). Each end beat produces eight beats on m_axis_*:
//   tdata is one digest word, most significant word first, tuser its index
//   0..7, tlast marks the eighth word.
// Timing:
//   A queue of FIFO_DEPTH beats decouples the input from the sequencer, so
//   the input keeps flowing while the output stalls or a block compresses,
//   until the queue is full. Every 64th message byte holds the sequencer
//   while the block compresses (64 rounds, one per cycle, then the chaining
//   add, until it sees the core idle); no new byte is taken meanwhile. An end
//   beat is followed by padding bytes, one or two such compressions and
//   then eight output beats, one per cycle while m_axis_tready is high.
// Reset:
//   rst_n clears the queue, the sequencer and the output valid flag and loads
//   the initial hash values. A stalled receiver holds the current word; the
//   sequencer waits on it and the queue fills before s_axis_tready drops.
module sha256_message_hasher_top #(
    parameter int FIFO_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    logic             item_valid;
    item_t            item;
    logic             pop;
    core_cmd_t        cmd;
    logic             core_busy;
    logic [7:0][31:0] chain;

    sha256_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (item_valid),
        .out_item  (item),
        .pop       (pop)
    );

    sha256_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .busy  (core_busy),
        .chain (chain)
    );

    sha256_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .cmd        (cmd),
        .core_busy  (core_busy),
        .chain      (chain),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (m_axis_tdata),
        .out_index  (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

@@ rtl/sha256_checker.sv @@
// Port-level checks for the SHA-256 hasher output stream, bound to the top level.
// No package dependencies.
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled digest beat changed");

    // Mark the last beat exactly on word seven
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast does not match word index");

    // Advance the word index by one within a digest
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        !m_axis_tvalid || (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
        else $error("digest word index skipped");

    // Start the next digest at word zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
        !m_axis_tvalid || (m_axis_tuser == 3'd0))
        else $error("digest did not restart at word zero");

endmodule

bind sha256_message_hasher_top sha256_checker u_sha256_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ bench/sha256_digest_checker.sv @@
// Beat monitor and digest predictor for the SHA-256 message hasher bench.
// Depends on sha256_pkg for the input kind codes and the last word index.
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_axis_tuser,   // [2:0] word_index
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    // Predictor state: chaining words, block buffer, fill and message length
    logic [31:0]  chain_words [0:7];
    logic [31:0]  blk_words [0:15];
    int           fill;
    logic [63:0]  bit_count;
    digest_beat_t digest_queue [$];
    digest_beat_t want;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned r);
        return (v >> r) | (v << (32 - r));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain_words[i] = HASH_INIT[i];
        fill = 0;
        bit_count = '0;
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    function automatic void compress_block_words();
        logic [31:0] sched [0:63];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, s0, s1, ch, maj;
        for (int t = 0; t < 16; t++)
            sched[t] = blk_words[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (int t = 0; t < 64; t++)
        begin
            s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
            ch  = (e & f) ^ (~e & g);
            t1  = h + s1 + ch + ROUND_K[t] + sched[t];
            s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
            maj = (a & b) ^ (a & c) ^ (b & c);
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + s0 + maj;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endfunction

    // Place one byte big-endian at the fill position
    function automatic void place_byte(input logic [7:0] b);
        blk_words[fill >> 2][8 * (3 - (fill & 3)) +: 8] = b;
        fill++;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        place_byte(b);
        bit_count += 64'd8;
        if (fill >= 64)
        begin
            compress_block_words();
            fill = 0;
        end
    endfunction

    // Pad, append the length, compress and queue the eight digest words
    function automatic void finish_message();
        digest_beat_t beat;
        place_byte(8'h80);
        if (fill > 56)
        begin
            while (fill < 64)
                place_byte(8'h00);
            compress_block_words();
            fill = 0;
        end
        while (fill < 56)
            place_byte(8'h00);
        blk_words[14] = bit_count[63:32];
        blk_words[15] = bit_count[31:0];
        compress_block_words();
        for (int k = 0; k < 8; k++)
        begin
            beat.word = chain_words[k];
            beat.idx  = 3'(k);
            beat.last = (3'(k) == LAST_WORD_IDX);
            digest_queue = {digest_queue, beat};
        end
        restart_message();
    endfunction

    initial
    begin
        fail_count = 0;
        words_pending = 0;
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
        restart_message();
    end

    // Compare output beats first, then absorb the input beat of this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected output beat: word %h index %0d last %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (m_axis_tdata !== want.word)
                    begin
                        $error("digest_word mismatch: expected %h, got %h",
                               want.word, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.idx)
                    begin
                        $error("word_index mismatch: expected %0d, got %0d",
                               want.idx, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_word mismatch: expected %0b, got %0b",
                               want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_END)
                    finish_message();
                else
                    absorb_byte(s_axis_tdata);
            end
            words_pending = digest_queue.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Top of the SHA-256 message hasher bench: clock, reset, byte-stream stimulus
// and verdict. Depends on sha256_pkg, sha256_message_hasher_top and sha256_digest_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    localparam int RANDOM_BEATS = 320;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = KIND_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int words_pending;
    int beats_sent = 0;
    int quiet_cycles = 0;
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    sha256_message_hasher_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_digest_checker digest_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive one input beat at the falling edge and hold it until accepted
    task automatic send_beat(input logic kind, input logic [7:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Random bytes of the given length, then an end beat with a junk byte
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
        send_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    // Drop the input and hold the sender until every digest word has come out
    task automatic wait_for_digests();
        s_axis_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    // Receiver: while rx_idle is set, stall a random number of cycles before each beat
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int len;
        int directed_beats;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty message; the byte on the end beat must be ignored
        send_beat(KIND_END, 8'hff);
        // "abc", back to back with no gaps
        send_beat(KIND_BYTE, 8'h61);
        send_beat(KIND_BYTE, 8'h62);
        send_beat(KIND_BYTE, 8'h63);
        send_beat(KIND_END, 8'h00);
        // Single byte extremes
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_END, 8'h00);
        send_beat(KIND_BYTE, 8'hff);
        send_beat(KIND_END, 8'hff);
        // Bytes that look like padding, with idling on both sides
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_beat(KIND_BYTE, 8'h80);
        send_beat(KIND_BYTE, 8'h7f);
        send_beat(KIND_END, 8'h55);
        send_beat(KIND_END, 8'haa);
        wait_for_digests();
        directed_beats = beats_sent;

        // Random messages, mostly short, some on the padding boundaries
        while (beats_sent < directed_beats + RANDOM_BEATS)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                    len = $urandom_range(0, 12);
                12, 13, 14, 15, 16:
                    case ($urandom_range(0, 5))
                        0:       len = 55;
                        1:       len = 56;
                        2:       len = 57;
                        3:       len = 63;
                        4:       len = 64;
                        default: len = 119;
                    endcase
                default:
                    len = $urandom_range(0, 130);
            endcase
            send_message(len);
            if ($urandom_range(0, 3) == 0)
                wait_for_digests();
        end

        // Drain and settle
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_core.sv
rtl/sha256_back.sv
rtl/sha256_message_hasher_top.sv
rtl/sha256_checker.sv
bench/sha256_digest_checker.sv
bench/tb.sv
